/* hdl/bfc_pkg.sv */
// ----------------------------------------------------------------------------
// bfc_pkg - shared definitions for the Blowfish CFB64 byte cipher
// Round count, key table sizes, command codes and the controller/datapath
// interface structs.
// ----------------------------------------------------------------------------
package bfc_pkg;

  // Feistel rounds and P-array size
  localparam int ROUNDS     = 16;
  localparam int P_WORDS    = ROUNDS + 2;
  localparam int P_IDX_W    = $clog2(P_WORDS);
  localparam bit ROUNDS_ODD = (ROUNDS % 2) == 1;

  // Feedback register value after reset
  localparam logic [63:0] IV_RESET = 64'hFEDC_BA98_7654_3210;

  // Input word command codes; the fourth code is unused and loads nothing, though restart still applies
  typedef enum logic [1:0] {
    CMD_LOAD_P  = 2'd0,
    CMD_LOAD_S  = 2'd1,
    CMD_PROCESS = 2'd2
  } cmd_t;

  // Controller to datapath
  typedef struct packed {
    logic               capture;  // input word taken this cycle
    logic               start;    // whiten left half, issue first S-box read
    logic               round;    // one Feistel round
    logic               finish;   // final whitening, write feedback register
    logic               emit;     // produce result byte into output register
    logic [P_IDX_W-1:0] p_sel;    // P-array entry for this cycle
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pos_zero;  // byte position is zero
    logic out_room;  // output register can take a word this cycle
  } dp_status_t;

endpackage

/* hdl/blowfish_cfb64_byte_cipher.sv */
// ----------------------------------------------------------------------------
// blowfish_cfb64_byte_cipher - Blowfish CFB64 byte stream cipher
// Key table loads and byte encrypt/decrypt over a stream interface.
// ----------------------------------------------------------------------------
// Load words write the P-array and S-boxes and give no result; the block
// stays idle after one, ready for the next word. A byte word at a non-zero
// feedback position goes straight to the byte step. At position zero, or on
// restart, the feedback register is first encrypted: a whitening step, one
// Feistel round per cycle (the four S-box banks are each read once a cycle,
// the address of the next round coming straight from the half just computed)
// and a final whitening step, then the byte step, which waits for room in the
// output register. Key tables power up undefined and must be loaded before
// use. The IV register is written through cfg_we/cfg_wdata and takes effect
// on the next word carrying restart. A result waiting in the output register
// does not hold off the next input word.
module blowfish_cfb64_byte_cipher (
  input  logic        clk,
  input  logic        rst,
  // IV register write
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // table_index[9:0], table_word[41:10],
                                 // data_byte[49:42], restart[50], zero[55:51]
  input  logic [2:0]  s_tuser,   // command[1:0], decrypt_mode[2]
  input  logic        s_tlast,   // last_byte
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // result_byte[7:0]
  output logic        m_tlast    // end_of_message
);
  import bfc_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  cmd_t       in_command;

  assign in_command = cmd_t'(s_tuser[1:0]);

  bfc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_command (in_command),
    .in_restart (s_tdata[50]),
    .status     (dp_status),
    .in_ready   (s_tready),
    .cmd        (dp_cmd)
  );

  bfc_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (dp_cmd),
    .status          (dp_status),
    .in_command      (in_command),
    .in_table_index  (s_tdata[9:0]),
    .in_table_word   (s_tdata[41:10]),
    .in_data_byte    (s_tdata[49:42]),
    .in_decrypt_mode (s_tuser[2]),
    .in_restart      (s_tdata[50]),
    .in_last_byte    (s_tlast),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_byte        (m_tdata),
    .out_last        (m_tlast)
  );

`ifndef SYNTH
  // A byte word always leaves idle, so no second word is taken meanwhile
  a_busy_after_byte: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && in_command == CMD_PROCESS) |=> !s_tready)
    else $error("input taken while a byte is in progress");

  // Datapath steps never overlap
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({dp_cmd.start, dp_cmd.round, dp_cmd.finish, dp_cmd.emit}))
    else $error("overlapping datapath commands");

  // A result is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !dp_cmd.emit)
    else $error("result register overwritten");

  // Encryption ends with whitening and then the byte step
  a_finish_then_byte: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.finish |=> (!s_tready && !dp_cmd.round && !dp_cmd.start))
    else $error("block finish not followed by byte step");
`endif

endmodule

/* hdl/bfc_ctrl.sv */
// ----------------------------------------------------------------------------
// bfc_ctrl - sequencer for the Blowfish CFB64 byte cipher
// Takes input words, steps the block encryption one round a cycle and
// hands the result byte to the output register.
// ----------------------------------------------------------------------------
module bfc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  bfc_pkg::cmd_t       in_command,
  input  logic                in_restart,
  input  bfc_pkg::dp_status_t status,
  output logic                in_ready,
  output bfc_pkg::dp_cmd_t    cmd
);
  import bfc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ROUND,
    ST_FINISH,
    ST_BYTE
  } state_t;

  state_t             state;
  logic [P_IDX_W-1:0] rnd;
  logic               accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // State and round counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rnd   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && in_command == CMD_PROCESS) begin
            // a restart zeroes the position, so a new block is due
            state <= (in_restart || status.pos_zero) ? ST_START : ST_BYTE;
          end
        end
        ST_START: begin
          rnd   <= P_IDX_W'(1);
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          if (rnd == P_IDX_W'(ROUNDS)) begin
            state <= ST_FINISH;
          end else begin
            rnd <= rnd + P_IDX_W'(1);
          end
        end
        ST_FINISH: begin
          state <= ST_BYTE;
        end
        ST_BYTE: begin
          if (status.out_room) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath commands
  always_comb begin
    cmd.capture = accept;
    cmd.start   = (state == ST_START);
    cmd.round   = (state == ST_ROUND);
    cmd.finish  = (state == ST_FINISH);
    cmd.emit    = (state == ST_BYTE) && status.out_room;
    unique case (state)
      ST_ROUND:  cmd.p_sel = rnd;
      ST_FINISH: cmd.p_sel = P_IDX_W'(ROUNDS + 1);
      default:   cmd.p_sel = '0;
    endcase
  end

endmodule

/* hdl/bfc_datapath.sv */
// ----------------------------------------------------------------------------
// bfc_datapath - key tables, Feistel datapath and CFB64 feedback
// Holds the P-array, four S-box banks, the feedback register, the byte
// position and the output register.
// ----------------------------------------------------------------------------
module bfc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  bfc_pkg::dp_cmd_t    cmd,
  output bfc_pkg::dp_status_t status,
  input  bfc_pkg::cmd_t       in_command,
  input  logic [9:0]          in_table_index,
  input  logic [31:0]         in_table_word,
  input  logic [7:0]          in_data_byte,
  input  logic                in_decrypt_mode,
  input  logic                in_restart,
  input  logic                in_last_byte,
  input  logic                cfg_we,
  input  logic [63:0]         cfg_wdata,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last
);
  import bfc_pkg::*;

  // Key tables
  logic [31:0] p_array [P_WORDS];
  logic [31:0] sbox0 [256];
  logic [31:0] sbox1 [256];
  logic [31:0] sbox2 [256];
  logic [31:0] sbox3 [256];
  logic [31:0] s0_q, s1_q, s2_q, s3_q;

  // Cipher state
  logic [63:0] init_vector;
  logic [63:0] feedback;
  logic [2:0]  pos;
  logic [31:0] half_a;  // half updated last, feeds the round function
  logic [31:0] half_b;

  // Latched byte command
  logic [7:0]  data_q;
  logic        dec_q;
  logic        last_q;

  logic [31:0] p_word;
  logic [31:0] f_val;
  logic [31:0] new_half;
  logic [31:0] start_half;
  logic [31:0] s_addr_src;
  logic [63:0] block_out;
  logic [5:0]  shift;
  logic [7:0]  ks_byte;
  logic [7:0]  res_byte;
  logic [7:0]  fb_byte;
  logic        load_s;

  assign status.pos_zero = (pos == 3'd0);
  assign status.out_room = !out_valid || out_ready;

  // Round function and Feistel step
  assign p_word     = p_array[cmd.p_sel];
  assign f_val      = ((s0_q + s1_q) ^ s2_q) + s3_q;
  assign new_half   = half_b ^ p_word ^ f_val;
  assign start_half = feedback[63:32] ^ p_word;
  assign s_addr_src = cmd.start ? start_half : new_half;

  // Output block: right half high, left half low
  assign block_out = ROUNDS_ODD ? {half_a ^ p_word, half_b}
                                : {half_b ^ p_word, half_a};

  // Keystream byte, most significant byte first
  assign shift    = 6'd56 - {pos, 3'b000};
  assign ks_byte  = 8'(feedback >> shift);
  assign res_byte = data_q ^ ks_byte;
  assign fb_byte  = dec_q ? data_q : res_byte;

  assign load_s = cmd.capture && in_command == CMD_LOAD_S;

  // S-box banks, one registered read each per cycle
  always_ff @(posedge clk) begin
    if (load_s && in_table_index[9:8] == 2'd0) begin
      sbox0[in_table_index[7:0]] <= in_table_word;
    end
    s0_q <= sbox0[s_addr_src[31:24]];
  end

  always_ff @(posedge clk) begin
    if (load_s && in_table_index[9:8] == 2'd1) begin
      sbox1[in_table_index[7:0]] <= in_table_word;
    end
    s1_q <= sbox1[s_addr_src[23:16]];
  end

  always_ff @(posedge clk) begin
    if (load_s && in_table_index[9:8] == 2'd2) begin
      sbox2[in_table_index[7:0]] <= in_table_word;
    end
    s2_q <= sbox2[s_addr_src[15:8]];
  end

  always_ff @(posedge clk) begin
    if (load_s && in_table_index[9:8] == 2'd3) begin
      sbox3[in_table_index[7:0]] <= in_table_word;
    end
    s3_q <= sbox3[s_addr_src[7:0]];
  end

  // P-array; indices past the end are dropped
  always_ff @(posedge clk) begin
    if (cmd.capture && in_command == CMD_LOAD_P &&
        in_table_index < 10'(P_WORDS)) begin
      p_array[in_table_index[P_IDX_W-1:0]] <= in_table_word;
    end
  end

  // Input latch and Feistel halves
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      data_q <= in_data_byte;
      dec_q  <= in_decrypt_mode;
      last_q <= in_last_byte;
    end
    if (cmd.start) begin
      half_a <= start_half;
      half_b <= feedback[31:0];
    end else if (cmd.round) begin
      half_a <= new_half;
      half_b <= half_a;
    end
  end

  // IV register
  always_ff @(posedge clk) begin
    if (rst) begin
      init_vector <= IV_RESET;
    end else if (cfg_we) begin
      init_vector <= cfg_wdata;
    end
  end

  // Feedback register and byte position
  always_ff @(posedge clk) begin
    if (rst) begin
      feedback <= IV_RESET;
      pos      <= 3'd0;
    end else begin
      priority if (cmd.capture && in_restart) begin
        feedback <= init_vector;
        pos      <= 3'd0;
      end else if (cmd.finish) begin
        feedback <= block_out;
      end else if (cmd.emit) begin
        feedback <= (feedback & ~(64'hFF << shift)) | (64'(fb_byte) << shift);
        pos      <= pos + 3'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte <= res_byte;
      out_last <= last_q;
    end
  end

endmodule

/* bench/tb_blowfish_cfb64_byte_cipher.sv */
// ----------------------------------------------------------------------------
// tb_blowfish_cfb64_byte_cipher - self-checking bench for the CFB64 cipher
// Loads a random key schedule, then drives directed and random byte traffic.
// Every accepted word is run through a bit-true Blowfish CFB64 predictor,
// and the byte stream out is compared word by word against its predictions.
// ----------------------------------------------------------------------------
module tb_blowfish_cfb64_byte_cipher;
  timeunit 1ns;
  timeprecision 1ps;

  import bfc_pkg::*;

  // command code that loads nothing in the block; restart still applies
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         S_WORDS    = 1024;
  localparam int         HOLD_LEN   = 400;
  localparam int         SETTLE     = ROUNDS + 8;

  // one input word, unpacked
  typedef struct {
    logic [1:0]  cmd;
    logic [9:0]  idx;
    logic [31:0] word;
    logic [7:0]  data;
    logic        dec;
    logic        restart;
    logic        last;
  } cipher_word_t;

  // one predicted output word
  typedef struct {
    logic [7:0] result_byte;
    logic       end_of_message;
  } cipher_byte_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [63:0] cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata   = '0;
  logic [2:0]  s_tuser   = '0;
  logic        s_tlast   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  blowfish_cfb64_byte_cipher dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // predictor state
  logic [63:0] iv_model       = IV_RESET;
  logic [63:0] feedback_model = IV_RESET;
  logic [2:0]  position_model = '0;
  logic [31:0] p_model [P_WORDS];
  logic [31:0] s_model [S_WORDS];

  cipher_byte_t expected_bytes [$];
  logic [7:0]   msg_buf [$];
  int           err_count      = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  int           hold_req       = 0;
  int           hold_served    = 0;
  int           hold_left      = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("blowfish_cfb64_byte_cipher: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    err_count++;
  endtask

  // Blowfish round function over the four S-box banks
  function automatic logic [31:0] feistel_f(input logic [31:0] x);
    return ((s_model[{2'd0, x[31:24]}] + s_model[{2'd1, x[23:16]}])
            ^ s_model[{2'd2, x[15:8]}]) + s_model[{2'd3, x[7:0]}];
  endfunction

  // one block encryption, left half in the upper 32 bits
  function automatic logic [63:0] encipher_block(input logic [63:0] blk);
    logic [31:0] l;
    logic [31:0] r;
    l = blk[63:32] ^ p_model[0];
    r = blk[31:0];
    for (int i = 1; i <= ROUNDS; i++) begin
      if (i % 2 == 1) r ^= p_model[i] ^ feistel_f(l);
      else            l ^= p_model[i] ^ feistel_f(r);
    end
    r ^= p_model[ROUNDS+1];
    return {r, l};
  endfunction

  // advance the predictor by one accepted word; queue a byte if one is due
  function automatic void cipher_model_step(input cipher_word_t w,
                                            output logic [7:0] res);
    logic [7:0]   ks;
    cipher_byte_t e;
    res = '0;
    if (w.restart) begin
      feedback_model = iv_model;
      position_model = '0;
    end
    case (w.cmd)
      CMD_LOAD_P:  if (w.idx < P_WORDS) p_model[w.idx] = w.word;
      CMD_LOAD_S:  s_model[w.idx] = w.word;
      CMD_PROCESS: begin
        if (position_model == 3'd0) feedback_model = encipher_block(feedback_model);
        ks  = feedback_model[63 - 8*position_model -: 8];
        res = w.data ^ ks;
        feedback_model[63 - 8*position_model -: 8] = w.dec ? w.data : res;
        position_model = position_model + 3'd1;
        e.result_byte    = res;
        e.end_of_message = w.last;
        expected_bytes.push_back(e);
      end
      default: ;
    endcase
  endfunction

  // offer one word, with a random gap first; predict on acceptance
  task automatic send_word(input cipher_word_t w, output logic [7:0] res);
    bit rdy;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, w.restart, w.data, w.word, w.idx};
    s_tuser  <= {w.dec, w.cmd};
    s_tlast  <= w.last;
    do begin
      @(negedge clk);
      rdy = s_tready;
      @(posedge clk);
    end while (!rdy);
    cipher_model_step(w, res);
  endtask

  function automatic cipher_word_t any_word();
    cipher_word_t w;
    w.cmd     = 2'($urandom);
    w.idx     = 10'($urandom);
    w.word    = $urandom;
    w.data    = 8'($urandom);
    w.dec     = 1'($urandom);
    w.restart = 1'($urandom);
    w.last    = 1'($urandom);
    return w;
  endfunction

  function automatic cipher_word_t byte_word(input logic [7:0] data, input logic dec,
                                             input logic restart, input logic last);
    cipher_word_t w;
    w         = any_word();
    w.cmd     = CMD_PROCESS;
    w.data    = data;
    w.dec     = dec;
    w.restart = restart;
    w.last    = last;
    return w;
  endfunction

  function automatic cipher_word_t load_word(input logic [1:0] cmd, input logic [9:0] idx,
                                             input logic [31:0] value,
                                             input logic restart);
    cipher_word_t w;
    w         = any_word();
    w.cmd     = cmd;
    w.idx     = idx;
    w.word    = value;
    w.restart = restart;
    return w;
  endfunction

  task automatic send_byte(input logic [7:0] data, input logic dec,
                           input logic restart, input logic last);
    logic [7:0] res;
    send_word(byte_word(data, dec, restart, last), res);
  endtask

  task automatic send_load(input logic [1:0] cmd, input logic [9:0] idx,
                           input logic [31:0] value, input logic restart);
    logic [7:0] res;
    send_word(load_word(cmd, idx, value, restart), res);
  endtask

  // a message of bytes; replay takes msg_buf as the payload
  // produced bytes are left in msg_buf
  task automatic send_message(input int len, input logic dec, input logic fresh,
                              input bit replay);
    logic [7:0] payload [$];
    logic [7:0] produced [$];
    logic [7:0] res;
    int         n;
    payload = msg_buf;
    n = replay ? payload.size() : len;
    for (int k = 0; k < n; k++) begin
      send_word(byte_word(replay ? payload[k] : 8'($urandom), dec,
                          fresh && (k == 0), k == n - 1), res);
      produced.push_back(res);
    end
    msg_buf = produced;
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  // drained and past any load still in flight
  task automatic wait_idle();
    wait_drain();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_iv(input logic [63:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    iv_model   = v;
  endtask

  // output side: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_served) begin
      hold_served = hold_req;
      hold_left   = HOLD_LEN;
      m_tready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker: the handshake seen here completes at the next edge
  always @(negedge clk) begin : check_results
    cipher_byte_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h", m_tdata));
      end else begin
        e = expected_bytes.pop_front();
        if (m_tdata !== e.result_byte)
          report_mismatch($sformatf("result byte %02h, predicted %02h",
                                    m_tdata, e.result_byte));
        if (m_tlast !== e.end_of_message)
          report_mismatch($sformatf("end of message %b, predicted %b",
                                    m_tlast, e.end_of_message));
      end
    end
  end

  // whole key schedule with random words; restart rides on some loads
  task automatic test_key_load();
    for (int i = 0; i < P_WORDS; i++)
      send_load(CMD_LOAD_P, 10'(i), $urandom, $urandom_range(15) == 0);
    for (int i = 0; i < S_WORDS; i++)
      send_load(CMD_LOAD_S, 10'(i), $urandom, $urandom_range(15) == 0);
  endtask

  task automatic test_directed();
    logic [7:0] res;
    // first block from the reset feedback value, bytes at both extremes
    send_byte(8'h00, 1'b0, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    // rest of the block and into the next one
    for (int k = 0; k < 8; k++) send_byte(8'($urandom), 1'b0, 1'b0, k == 7);
    // restart part way through a block, decrypting
    send_byte(8'h5A, 1'b1, 1'b0, 1'b0);
    send_byte(8'hA5, 1'b1, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1, 1'b1);
    // P loads past the end of the array are dropped
    send_load(CMD_LOAD_P, 10'(P_WORDS), 32'hFFFF_FFFF, 1'b0);
    send_load(CMD_LOAD_P, 10'h3FF, 32'hFFFF_FFFF, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0, 1'b0);
    // unused command still honours restart
    send_word('{cmd: CMD_UNUSED, idx: 10'h3FF, word: 32'hFFFF_FFFF, data: 8'hFF,
                dec: 1'b1, restart: 1'b1, last: 1'b1}, res);
    send_byte(8'h3C, 1'b0, 1'b0, 1'b0);
    // key words rewritten between bytes, extremes of index and word
    send_load(CMD_LOAD_S, 10'h3FF, 32'hFFFF_FFFF, 1'b1);
    send_load(CMD_LOAD_P, 10'(P_WORDS - 1), 32'h0000_0000, 1'b0);
    send_load(CMD_LOAD_S, 10'h000, 32'h0000_0000, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b0, 1'b1);
  endtask

  // mostly messages, some key rewrites and noise
  task automatic run_random_traffic(input int n_items);
    int         sent;
    int         pick;
    int         len;
    logic [7:0] res;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = $urandom_range(16, 1);
        if ($urandom_range(3) == 0) begin
          // round trip: encrypt then decrypt the ciphertext from the IV
          send_message(len, 1'b0, 1'b1, 1'b0);
          send_message(len, 1'b1, 1'b1, 1'b1);
          sent += 2 * len;
        end else begin
          send_message(len, 1'($urandom), $urandom_range(9) < 7, 1'b0);
          sent += len;
        end
      end else if (pick < 80) begin
        send_load(CMD_LOAD_S, 10'($urandom), $urandom, $urandom_range(7) == 0);
        sent++;
      end else if (pick < 88) begin
        send_load(CMD_LOAD_P,
                  ($urandom_range(3) == 0) ? 10'($urandom_range(1023, P_WORDS))
                                           : 10'($urandom_range(P_WORDS - 1)),
                  $urandom, $urandom_range(7) == 0);
        sent++;
      end else if (pick < 93) begin
        send_word(load_word(CMD_UNUSED, 10'($urandom), $urandom, 1'($urandom)), res);
      end else begin
        send_word(any_word(), res);
        sent++;
      end
    end
  endtask

  task automatic test_iv_phase(input logic [63:0] iv, input int send_pct,
                               input int recv_pct, input int n_items);
    wait_idle();
    write_iv(iv);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    run_random_traffic(n_items);
  endtask

  // output held off long enough for the block to stall its input
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req++;
    send_message(40, 1'b0, 1'b1, 1'b0);
  endtask

  // sender waits for every result, then carries on the same stream
  task automatic test_sender_pause();
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    send_message(12, 1'b0, 1'b1, 1'b0);
    wait_drain();
    send_message(12, 1'b0, 1'b0, 1'b0);
    wait_drain();
    send_message(5, 1'b1, 1'b0, 1'b0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_key_load();
    test_directed();
    test_iv_phase(64'h0, 0, 0, 100);
    test_iv_phase(64'hFFFF_FFFF_FFFF_FFFF, 65, 0, 100);
    test_iv_phase({$urandom, $urandom}, 0, 65, 100);
    test_iv_phase({$urandom, $urandom}, 23, 23, 100);
    test_backpressure();
    test_sender_pause();
    wait_idle();
    if (err_count == 0) begin
      $display("blowfish_cfb64_byte_cipher: match");
    end else begin
      $display("blowfish_cfb64_byte_cipher: mismatch");
    end
    $finish;
  end

endmodule
